// ===== rtl/kmp_pkg.sv =====
// kmp_pkg: shared constants and types for the string matcher.
// Holds operation and result codes, reset values and the cell control struct.
// No dependencies.
`default_nettype none

package kmp_pkg;

   // Operation codes of an input item
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_TEXT   = 2'd2;

   // Result kinds
   localparam logic KIND_MATCH = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   // Defaults and limits
   localparam int          MAX_PATTERN_DEFAULT = 16;
   localparam logic [15:0] MAX_REPORTED_RESET  = 16'hFFFF;
   localparam logic [31:0] SAT32               = 32'hFFFF_FFFF;

   // Control broadcast from the top level to every cell
   typedef struct packed {
      logic       append;      // write the pattern byte at the current length
      logic       step;        // advance all cells by one text byte
      logic       clear;       // drop all partial matches
      logic [7:0] byte_value;  // pattern or text character
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/kmp_cell.sv =====
// kmp_cell: one position of the pattern in the matching chain.
// Holds one pattern byte and a flag telling that the text seen so far ends in
// the pattern prefix through this position. Depends on kmp_pkg.
`default_nettype none

module kmp_cell #(
   parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEFAULT,
   parameter int CELL_INDEX  = 0,
   localparam int LEN_W      = $clog2(MAX_PATTERN + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire kmp_pkg::cell_ctrl_type ctrl,
   input  wire logic [LEN_W-1:0]      pattern_length,
   input  wire logic                  prev_active,   // flag of the left neighbor
   output logic                       active,        // flag handed to the right
   output logic                       hit            // full pattern ends here
);

   localparam logic [LEN_W-1:0] CellIndex = LEN_W'(CELL_INDEX);
   localparam logic [LEN_W-1:0] CellCount = LEN_W'(CELL_INDEX + 1);

   logic [7:0] pattern_byte_ff;
   logic       active_ff;
   logic       active_in;
   logic       in_use;
   logic       extend;

   // Cell takes part only while it lies inside the pattern
   assign in_use = (CellIndex < pattern_length);

   // Prefix through this cell extends when the left one matched and chars agree
   assign extend = ctrl.step && in_use && prev_active &&
                   (pattern_byte_ff == ctrl.byte_value);

   assign hit = extend && (pattern_length == CellCount);

   always_comb begin
      active_in = active_ff;
      if (ctrl.clear) begin
         active_in = 1'b0;
      end else if (ctrl.step) begin
         active_in = extend;
      end
   end

   // Match flag
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   // Pattern byte, written once when appended at this position
   always_ff @(posedge clock) begin
      if (ctrl.append && (pattern_length == CellIndex)) begin
         pattern_byte_ff <= ctrl.byte_value;
      end
   end

   assign active = active_ff;

endmodule

`default_nettype wire

// ===== rtl/kmp_string_matcher.sv =====
// kmp_string_matcher: top level of the pattern search block.
// Instantiates a row of kmp_cell, holds text counters and the result register.
// Depends on kmp_pkg and kmp_cell.
//
// Usage:
//  - req_* carries items: clear pattern, append a pattern byte, or a text byte.
//    A transfer happens when req_valid is high and req_stall is low.
//  - rsp_* returns match results (start index, running count) and a done
//    result with the total on the byte marked req_last_of_text.
//  - csr_* writes max_reported (csr_ready is always high); write only while idle.
//  - Every text byte advances all cells of the chain together, so the
//    search state is ready for the next byte in the following cycle.
//  - Results appear in rsp_* the cycle after the causing transfer. A two-entry
//    result register drains one result per cycle while rsp_stall is low; items
//    with at most one result then flow at one per cycle; one with two stalls input.
//  - While the receiver stalls, the pending result holds and req_stall stays
//    high until the last pending result is being transferred.
//  - Reset (synchronous, active high) empties the pattern, clears the text
//    counters, drops pending results and sets max_reported to 65535.
`default_nettype none

module kmp_string_matcher #(
   parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_last_of_text,
   // results
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [31:0]      rsp_match_start,
   output logic [31:0]      rsp_match_total,
   output logic             rsp_last_result,
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_max_reported
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   logic [LEN_W-1:0]       pattern_length_ff, pattern_length_in;
   logic [31:0]            text_position_ff,  text_position_in;
   logic [31:0]            match_counter_ff,  match_counter_in;
   logic [15:0]            max_reported_ff;
   logic                   match_pend_ff, match_pend_in;
   logic                   done_pend_ff,  done_pend_in;
   logic                   done_last_ff,  done_last_in;
   logic [31:0]            match_start_ff, match_start_in;
   logic [31:0]            total_ff,       total_in;

   kmp_pkg::cell_ctrl_type cell_ctrl;
   logic [MAX_PATTERN:0]   chain;
   logic [MAX_PATTERN-1:0] hit_vec;
   logic                   hit;
   logic                   rsp_take, req_take;
   logic                   match_left, done_left;
   logic                   is_clear, is_append, is_text;
   logic [31:0]            count_next;
   logic [31:0]            len_minus1;

   // Handshakes
   assign rsp_valid  = match_pend_ff || done_pend_ff;
   assign rsp_take   = rsp_valid && !rsp_stall;
   assign match_left = match_pend_ff && !rsp_take;
   assign done_left  = done_pend_ff && !(rsp_take && !match_pend_ff);
   assign req_stall  = match_left || done_left;
   assign req_take   = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // Operation decode
   assign is_clear  = req_take && (req_operation == kmp_pkg::OP_CLEAR);
   assign is_append = req_take && (req_operation == kmp_pkg::OP_APPEND);
   assign is_text   = req_take && (req_operation == kmp_pkg::OP_TEXT);

   assign cell_ctrl.append     = is_append;
   assign cell_ctrl.step       = is_text;
   assign cell_ctrl.clear      = is_clear || is_append || (is_text && req_last_of_text);
   assign cell_ctrl.byte_value = req_byte_value;

   // Chain of cells; the leftmost always sees an empty prefix as matched
   assign chain[0] = 1'b1;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      kmp_cell #(
         .MAX_PATTERN (MAX_PATTERN),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (cell_ctrl),
         .pattern_length (pattern_length_ff),
         .prev_active    (chain[i]),
         .active         (chain[i+1]),
         .hit            (hit_vec[i])
      );
   end

   assign hit = |hit_vec;

   // Count and start index of a match
   assign count_next = (hit && (match_counter_ff != kmp_pkg::SAT32)) ?
                       match_counter_ff + 32'd1 : match_counter_ff;
   assign len_minus1 = 32'(pattern_length_ff) - 32'd1;

   // Next state of pattern, text counters and result register
   always_comb begin
      pattern_length_in = pattern_length_ff;
      text_position_in  = text_position_ff;
      match_counter_in  = match_counter_ff;
      match_pend_in     = match_left;
      done_pend_in      = done_left;
      done_last_in      = done_last_ff;
      match_start_in    = match_start_ff;
      total_in          = total_ff;

      if (is_clear) begin
         pattern_length_in = '0;
         text_position_in  = '0;
         match_counter_in  = '0;
      end else if (is_append) begin
         if (pattern_length_ff < LEN_W'(MAX_PATTERN)) begin
            pattern_length_in = pattern_length_ff + LEN_W'(1);
         end
         text_position_in = '0;
         match_counter_in = '0;
      end else if (is_text) begin
         match_pend_in  = hit && (match_counter_ff < {16'd0, max_reported_ff});
         done_pend_in   = req_last_of_text;
         done_last_in   = req_last_of_text;
         total_in       = count_next;
         match_start_in = (text_position_ff >= len_minus1) ?
                          text_position_ff - len_minus1 : 32'd0;
         if (req_last_of_text) begin
            text_position_in = '0;
            match_counter_in = '0;
         end else begin
            match_counter_in = count_next;
            if (text_position_ff != kmp_pkg::SAT32) begin
               text_position_in = text_position_ff + 32'd1;
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         text_position_ff  <= '0;
         match_counter_ff  <= '0;
         match_pend_ff     <= 1'b0;
         done_pend_ff      <= 1'b0;
         max_reported_ff   <= kmp_pkg::MAX_REPORTED_RESET;
      end else begin
         pattern_length_ff <= pattern_length_in;
         text_position_ff  <= text_position_in;
         match_counter_ff  <= match_counter_in;
         match_pend_ff     <= match_pend_in;
         done_pend_ff      <= done_pend_in;
         if (csr_valid && csr_ready) begin
            max_reported_ff <= csr_max_reported;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      done_last_ff   <= done_last_in;
      match_start_ff <= match_start_in;
      total_ff       <= total_in;
   end

   // Match slot goes out first, then the done slot
   assign rsp_kind        = match_pend_ff ? kmp_pkg::KIND_MATCH : kmp_pkg::KIND_DONE;
   assign rsp_match_start = match_pend_ff ? match_start_ff : 32'd0;
   assign rsp_match_total = total_ff;
   assign rsp_last_result = match_pend_ff ? !done_last_ff : 1'b1;

endmodule

`default_nettype wire

// ===== tb/sv/kmp_search_scoreboard.sv =====
`timescale 1ns / 1ps
// kmp_search_check_pkg: scoreboard for the KMP string matcher testbench.
// Predicts match and done results per accepted item; depends on kmp_pkg.
package kmp_search_check_pkg;

   localparam int PATTERN_DEPTH = kmp_pkg::MAX_PATTERN_DEFAULT;

   // One result transfer as seen on the rsp_ channel
   typedef struct packed {
      logic        kind;
      logic [31:0] start;
      logic [31:0] total;
      logic        last;
   } search_result_type;

   class kmp_search_scoreboard;

      // predictor state, same widths as the block
      logic [7:0]        pattern_bytes [PATTERN_DEPTH];
      logic [4:0]        border_len [PATTERN_DEPTH];
      logic [4:0]        pat_len;
      logic [4:0]        border_run;
      logic [4:0]        matched;
      logic [31:0]       text_pos;
      logic [31:0]       hit_count;
      logic [15:0]       report_limit;

      search_result_type pending_q [$];
      int unsigned       errors;
      int unsigned       results_checked;
      int unsigned       match_results;
      int unsigned       done_results;

      function new();
         pat_len         = '0;
         border_run      = '0;
         report_limit    = kmp_pkg::MAX_REPORTED_RESET;
         errors          = 0;
         results_checked = 0;
         match_results   = 0;
         done_results    = 0;
         restart_text();
      endfunction

      function void restart_text();
         matched   = '0;
         text_pos  = '0;
         hit_count = '0;
      endfunction

      function void set_limit(logic [15:0] value);
         report_limit = value;
      endfunction

      function int unsigned pending_count();
         return pending_q.size();
      endfunction

      task report(string msg);
         if (errors < 40)
            $display("tb mismatch: %s", msg);
         errors++;
      endtask

      // Work out the results of one accepted input transfer
      function void note_input(logic [1:0] op, logic [7:0] ch, logic last);
         logic [4:0]        run;
         logic [4:0]        j;
         logic [31:0]       prior;
         search_result_type r;
         case (op)
            kmp_pkg::OP_CLEAR: begin
               pat_len    = '0;
               border_run = '0;
               restart_text();
            end
            kmp_pkg::OP_APPEND: begin
               // extend the border table by one entry; full pattern drops the byte
               if (pat_len < PATTERN_DEPTH) begin
                  pattern_bytes[pat_len[3:0]] = ch;
                  run = border_run;
                  if (pat_len == 0) begin
                     run = '0;
                  end else begin
                     while (run > 0 && pattern_bytes[run[3:0]] != ch)
                        run = border_len[4'(run - 5'd1)];
                     if (pattern_bytes[run[3:0]] == ch)
                        run++;
                  end
                  border_len[pat_len[3:0]] = run;
                  border_run               = run;
                  pat_len++;
               end
               restart_text();
            end
            kmp_pkg::OP_TEXT: begin
               j = matched;
               if (pat_len > 0) begin
                  if (j >= pat_len)
                     j = '0;
                  while (j > 0 && pattern_bytes[j[3:0]] != ch)
                     j = border_len[4'(j - 5'd1)];
                  if (pattern_bytes[j[3:0]] == ch)
                     j++;
                  if (j == pat_len) begin
                     prior = hit_count;
                     if (hit_count != kmp_pkg::SAT32)
                        hit_count++;
                     // only the first report_limit matches are reported
                     if (prior < {16'd0, report_limit}) begin
                        r.kind  = kmp_pkg::KIND_MATCH;
                        r.start = (text_pos >= 32'(pat_len) - 32'd1) ?
                                  text_pos - (32'(pat_len) - 32'd1) : 32'd0;
                        r.total = hit_count;
                        r.last  = !last;
                        pending_q.push_back(r);
                     end
                     j = border_len[4'(pat_len - 5'd1)];
                  end
               end else begin
                  j = '0;
               end
               matched = j;
               if (text_pos != kmp_pkg::SAT32)
                  text_pos++;
               // done result closes the text and restarts its state
               if (last) begin
                  r = '{kmp_pkg::KIND_DONE, 32'd0, hit_count, 1'b1};
                  pending_q.push_back(r);
                  restart_text();
               end
            end
            default: ;
         endcase
      endfunction

      // Compare one result transfer with the oldest expectation
      task check_result(search_result_type got);
         search_result_type want;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected result kind %0d start %0d total %0d last %0d",
                             got.kind, got.start, got.total, got.last));
            return;
         end
         want = pending_q.pop_front();
         results_checked++;
         if (want.kind == kmp_pkg::KIND_MATCH)
            match_results++;
         else
            done_results++;
         if (got.kind !== want.kind)
            report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
         if (got.start !== want.start)
            report($sformatf("match_start %0d, expected %0d", got.start, want.start));
         if (got.total !== want.total)
            report($sformatf("match_total %0d, expected %0d", got.total, want.total));
         if (got.last !== want.last)
            report($sformatf("last_result %0d, expected %0d", got.last, want.last));
      endtask

   endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: top level that drives kmp_string_matcher with directed and random items.
// Depends on kmp_pkg, kmp_search_check_pkg and the matcher RTL.
module testbench;

   localparam logic [1:0]  OP_UNUSED   = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASE_ITEMS = 160;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_operation;
   logic [7:0]  req_byte_value;
   logic        req_last_of_text;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_kind;
   logic [31:0] rsp_match_start;
   logic [31:0] rsp_match_total;
   logic        rsp_last_result;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_max_reported;

   kmp_search_check_pkg::kmp_search_scoreboard board;
   bit          no_idle;
   int unsigned items_sent;
   int unsigned limit_writes;
   int unsigned cycle_count;

   kmp_string_matcher dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_byte_value   (req_byte_value),
      .req_last_of_text (req_last_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_match_start  (rsp_match_start),
      .rsp_match_total  (rsp_match_total),
      .rsp_last_result  (rsp_last_result),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_reported (csr_max_reported)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result side: random stall before each transfer, check at the accepting edge
   initial begin
      int unsigned                             hold;
      kmp_search_check_pkg::search_result_type got;
      rsp_stall = 1'b0;
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 5);
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1 || reset);
         got = '{rsp_kind, rsp_match_start, rsp_match_total, rsp_last_result};
         board.check_result(got);
         @(negedge clock);
      end
   end

   // Send one item; returns at the falling edge after its transfer
   task automatic send_item(input logic [1:0] op, input logic [7:0] ch, input logic last);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_operation    = op;
      req_byte_value   = ch;
      req_last_of_text = last;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_input(op, ch, last);
      if (op != OP_UNUSED)
         items_sent++;
      @(negedge clock);
   endtask

   // Hold off input until every expected result has been transferred
   task automatic wait_drained();
      req_valid = 1'b0;
      while (board.pending_count() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      wait_drained();
      csr_valid        = 1'b1;
      csr_max_reported = value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.set_limit(value);
      limit_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // One pattern load followed by a text built from the pattern's symbols
   task automatic send_search(input int unsigned forced_len);
      logic [7:0]  sym_a;
      logic [7:0]  sym_b;
      logic [7:0]  ch;
      logic [7:0]  pat_copy [$];
      int unsigned plen;
      int unsigned tlen;
      int unsigned cursor;
      int unsigned pick;
      sym_a  = 8'($urandom);
      sym_b  = 8'($urandom);
      cursor = 0;
      if (forced_len != 0)
         plen = forced_len;
      else if ($urandom_range(0, 7) == 0)
         plen = $urandom_range(14, 18);
      else
         plen = $urandom_range(1, 4);
      // sometimes skip the clear so the pattern grows further
      if (forced_len != 0 || $urandom_range(0, 4) != 0)
         send_item(kmp_pkg::OP_CLEAR, 8'($urandom), 1'($urandom));
      for (int i = 0; i < plen; i++) begin
         ch = $urandom_range(0, 1) ? sym_a : sym_b;
         pat_copy.push_back(ch);
         send_item(kmp_pkg::OP_APPEND, ch, 1'($urandom));
      end
      tlen = $urandom_range(1, 40);
      for (int i = 0; i < tlen; i++) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) begin
            ch = 8'($urandom);
         end else if (pick < 8) begin
            ch = pat_copy[cursor % pat_copy.size()];
            cursor = ($urandom_range(0, 9) == 0) ? 0 : cursor + 1;
         end else begin
            ch = $urandom_range(0, 1) ? sym_a : sym_b;
         end
         // most texts end properly; the rest are cut off by the next pattern edit
         send_item(kmp_pkg::OP_TEXT, ch, (i == tlen - 1) && ($urandom_range(0, 5) != 0));
      end
   endtask

   task automatic run_phase(input logic [15:0] limit, input bit calm,
                            input bit with_full);
      int unsigned stop_at;
      write_limit(limit);
      no_idle = calm;
      stop_at = items_sent + PHASE_ITEMS;
      if (with_full)
         send_search(kmp_pkg::MAX_PATTERN_DEFAULT + 1);
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0)
            send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
         else
            send_search(0);
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = kmp_pkg::OP_CLEAR;
      req_byte_value   = 8'h00;
      req_last_of_text = 1'b0;
      csr_valid        = 1'b0;
      csr_max_reported = 16'h0000;
      no_idle          = 1'b0;
      items_sent       = 0;
      limit_writes     = 0;
      board            = new();
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // empty pattern: no matches, done result with zero total
      send_item(kmp_pkg::OP_TEXT, 8'h41, 1'b0);
      send_item(kmp_pkg::OP_TEXT, 8'hFF, 1'b1);
      // unused operation is dropped even with the last flag set
      send_item(OP_UNUSED, 8'hAA, 1'b1);
      // pattern "aa"; last flag on a pattern edit is ignored
      send_item(kmp_pkg::OP_APPEND, 8'h61, 1'b1);
      send_item(kmp_pkg::OP_APPEND, 8'h61, 1'b0);
      // overlapping matches, then match and done on the same byte
      send_item(kmp_pkg::OP_TEXT, 8'h61, 1'b0);
      send_item(kmp_pkg::OP_TEXT, 8'h61, 1'b0);
      send_item(kmp_pkg::OP_TEXT, 8'h61, 1'b0);
      send_item(kmp_pkg::OP_TEXT, 8'h62, 1'b0);
      send_item(kmp_pkg::OP_TEXT, 8'h61, 1'b0);
      send_item(kmp_pkg::OP_TEXT, 8'h61, 1'b1);
      // byte extremes
      send_item(kmp_pkg::OP_CLEAR, 8'hFF, 1'b1);
      send_item(kmp_pkg::OP_APPEND, 8'h00, 1'b0);
      send_item(kmp_pkg::OP_APPEND, 8'hFF, 1'b0);
      send_item(kmp_pkg::OP_TEXT, 8'hFF, 1'b0);
      send_item(kmp_pkg::OP_TEXT, 8'h00, 1'b0);
      send_item(kmp_pkg::OP_TEXT, 8'hFF, 1'b1);
      // pattern edit mid-text drops the partial text
      send_item(kmp_pkg::OP_TEXT, 8'h00, 1'b0);
      send_item(kmp_pkg::OP_APPEND, 8'h00, 1'b0);
      send_item(kmp_pkg::OP_TEXT, 8'hFF, 1'b1);

      // random phases over several report limits, two without idling
      run_phase(kmp_pkg::MAX_REPORTED_RESET, 1'b0, 1'b1);
      run_phase(16'd0, 1'b0, 1'b0);
      run_phase(16'd1, 1'b1, 1'b0);
      run_phase(16'd2, 1'b0, 1'b0);
      run_phase(16'($urandom_range(3, 65534)), 1'b0, 1'b0);
      run_phase(16'hFFFF, 1'b1, 1'b0);

      wait_drained();
      repeat (10) @(negedge clock);
      if (board.pending_count() != 0)
         board.report($sformatf("%0d results never arrived", board.pending_count()));

      $display("tb: %0d items sent, %0d report limit writes (0 to 65535)",
               items_sent, limit_writes);
      $display("tb: %0d results checked, %0d match and %0d done, %0d mismatches",
               board.results_checked, board.match_results, board.done_results,
               board.errors);
      if (board.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
